FILE: hw/rtl/rmth_pkg.sv
package rmth_pkg;

    localparam int DATA_W         = 32;
    localparam int DEF_HEAP_DEPTH = 4096;

    typedef struct packed {
        logic accept;
        logic push_start;
        logic use_moved;
        logic up_step;
        logic pop_start;
        logic pop_load;
        logic down_step;
        logic emit;
        logic refused;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic up_done;
        logic down_done;
        logic need_l2u;
        logic need_u2l;
    } t_stat;

endpackage

FILE: hw/rtl/rmth_ram.sv
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: hw/rtl/rmth_dp.sv
module rmth_dp
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cmd                                i_cmd,
    output t_stat                               o_stat,
    input  logic [DATA_W-1:0]                   i_sample,
    output logic [DATA_W-1:0]                   o_median,
    output logic [$clog2(2*HEAP_DEPTH)-1:0]     o_item_count,
    output logic                                o_refused
);

    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int HW    = AW + 1;
    localparam int CW    = $clog2(2 * HEAP_DEPTH);
    localparam int LIMIT = 2 * HEAP_DEPTH - 2;

    function automatic logic ranks(input logic is_min, input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
        return is_min ? (a < b) : (a > b);
    endfunction

    function automatic logic [AW-1:0] parent(input logic [AW-1:0] p);
        logic [AW-1:0] d;
        d = p - 1'b1;
        return (p == '0) ? '0 : (d >> 1);
    endfunction

    logic [HW-1:0]              r_lcnt, n_lcnt, r_ucnt, n_ucnt, r_n, n_n;
    logic signed [DATA_W-1:0]   r_ltop, r_utop, r_val, n_val, r_moved, n_moved;
    logic                       r_side, n_side;
    logic [AW-1:0]              r_pos, n_pos;
    logic [DATA_W-1:0]          r_median;
    logic [CW-1:0]              r_count;
    logic                       r_refused;

    logic                       wen;
    logic [AW-1:0]              waddr, raddr_a, raddr_b;
    logic signed [DATA_W-1:0]   wdata, rd_a, rd_b, median;
    logic [DATA_W-1:0]          l_rda, l_rdb, u_rda, u_rdb;
    logic [AW+1:0]              total;
    logic                       goes_upper, ps_side, src, up_done, sel_l, sel_r;
    logic [HW-1:0]              ps_cnt, pop_cnt;
    logic [AW-1:0]              par, best;
    logic [AW+1:0]              kid_l, kid_r;
    logic [AW:0]                nxt_l, nxt_r;
    logic signed [DATA_W-1:0]   bv1;

    rmth_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_DEPTH)) u_lower (
        .i_clk     (i_clk),
        .i_we      (wen && !r_side),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (l_rda),
        .o_rdata_b (l_rdb)
    );

    rmth_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_DEPTH)) u_upper (
        .i_clk     (i_clk),
        .i_we      (wen && r_side),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (u_rda),
        .o_rdata_b (u_rdb)
    );

    assign rd_a  = $signed(r_side ? u_rda : l_rda);
    assign rd_b  = $signed(r_side ? u_rdb : l_rdb);
    assign total = {1'b0, r_lcnt} + {1'b0, r_ucnt};

    always_comb begin
        if (r_lcnt == '0 && r_ucnt == '0) begin
            median = '0;
        end else if (r_lcnt >= r_ucnt) begin
            median = r_ltop;
        end else begin
            median = r_utop;
        end
    end

    // sift-up compare against the parent read last cycle
    assign par     = parent(r_pos);
    assign up_done = (r_pos == '0) || !ranks(r_side, r_val, rd_a);

    // sift-down: pick the best of hole value and both children
    assign kid_l = {1'b0, r_pos, 1'b1};
    assign kid_r = kid_l + 1'b1;
    assign sel_l = (kid_l < {1'b0, r_n}) && ranks(r_side, rd_a, r_val);
    assign bv1   = sel_l ? rd_a : r_val;
    assign sel_r = (kid_r < {1'b0, r_n}) && ranks(r_side, rd_b, bv1);
    assign best  = sel_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
    assign nxt_l = {best, 1'b1};
    assign nxt_r = nxt_l + 1'b1;

    assign goes_upper = (r_lcnt != '0) && !($signed(i_sample) < r_ltop);
    assign ps_side    = i_cmd.use_moved ? !r_side : r_side;
    assign ps_cnt     = ps_side ? r_ucnt : r_lcnt;
    assign src        = o_stat.need_u2l;
    assign pop_cnt    = (src ? r_ucnt : r_lcnt) - 1'b1;

    always_comb begin
        n_lcnt  = r_lcnt;
        n_ucnt  = r_ucnt;
        n_n     = r_n;
        n_val   = r_val;
        n_moved = r_moved;
        n_side  = r_side;
        n_pos   = r_pos;
        wen     = 1'b0;
        waddr   = r_pos;
        wdata   = r_val;
        raddr_a = '0;
        raddr_b = '0;
        if (i_cmd.accept) begin
            n_val  = $signed(i_sample);
            n_side = goes_upper;
        end
        if (i_cmd.push_start) begin
            n_side  = ps_side;
            if (i_cmd.use_moved) begin
                n_val = r_moved;
            end
            n_pos   = ps_cnt[AW-1:0];
            raddr_a = parent(ps_cnt[AW-1:0]);
            if (ps_side) begin
                n_ucnt = r_ucnt + 1'b1;
            end else begin
                n_lcnt = r_lcnt + 1'b1;
            end
        end
        if (i_cmd.up_step) begin
            wen = 1'b1;
            if (!up_done) begin
                wdata   = rd_a;
                n_pos   = par;
                raddr_a = parent(par);
            end
        end
        if (i_cmd.pop_start) begin
            n_side  = src;
            n_moved = src ? r_utop : r_ltop;
            n_n     = pop_cnt;
            raddr_a = pop_cnt[AW-1:0];
            if (src) begin
                n_ucnt = pop_cnt;
            end else begin
                n_lcnt = pop_cnt;
            end
        end
        if (i_cmd.pop_load) begin
            n_val   = rd_a;
            n_pos   = '0;
            raddr_a = AW'(1);
            raddr_b = AW'(2);
        end
        if (i_cmd.down_step) begin
            wen   = 1'b1;
            wdata = sel_r ? rd_b : bv1;
            if (sel_l || sel_r) begin
                n_pos   = best;
                raddr_a = nxt_l[AW-1:0];
                raddr_b = nxt_r[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0;
            r_ucnt <= '0;
        end else begin
            r_lcnt <= n_lcnt;
            r_ucnt <= n_ucnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_val   <= n_val;
        r_moved <= n_moved;
        r_side  <= n_side;
        r_pos   <= n_pos;
        if (wen && waddr == '0) begin
            if (r_side) begin
                r_utop <= wdata;
            end else begin
                r_ltop <= wdata;
            end
        end
        if (i_cmd.emit) begin
            r_median  <= median;
            r_count   <= total[CW-1:0];
            r_refused <= i_cmd.refused;
        end
    end

    assign o_stat.full      = total >= (AW+2)'(LIMIT);
    assign o_stat.up_done   = up_done;
    assign o_stat.down_done = !sel_l && !sel_r;
    assign o_stat.need_l2u  = {1'b0, r_lcnt} > ({1'b0, r_ucnt} + 1'b1);
    assign o_stat.need_u2l  = {1'b0, r_ucnt} > ({1'b0, r_lcnt} + 1'b1);

    assign o_median     = r_median;
    assign o_item_count = r_count;
    assign o_refused    = r_refused;

endmodule

FILE: hw/rtl/rmth_ctrl.sv
module rmth_ctrl
    import rmth_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_UP    = 7'b0000100,
        S_BAL   = 7'b0001000,
        S_POPLD = 7'b0010000,
        S_DOWN  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase, n_phase;
    logic   r_ref, n_ref;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_ref   = r_ref;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_phase      = 1'b0;
                    n_ref        = i_stat.full;
                    n_state      = i_stat.full ? S_EMIT : S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push_start = 1'b1;
                o_cmd.use_moved  = r_phase;
                n_state          = S_UP;
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.up_done) begin
                    n_state = r_phase ? S_EMIT : S_BAL;
                end
            end
            S_BAL: begin
                if (i_stat.need_l2u || i_stat.need_u2l) begin
                    o_cmd.pop_start = 1'b1;
                    n_state         = S_POPLD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_POPLD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_DOWN;
            end
            S_DOWN: begin
                o_cmd.down_step = 1'b1;
                if (i_stat.down_done) begin
                    n_phase = 1'b1;
                    n_state = S_PUSH;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.refused = r_ref;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_ref   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ref   <= n_ref;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/running_median_two_heaps.sv
// running median of a signed sample stream, held in a max-heap (lower half)
// and a min-heap (upper half), each in its own RAM of HEAP_DEPTH words
// input channel: i_valid/o_stall with i_sample; a word is taken when
// i_valid is high and o_stall low; o_stall is high while an item is at work
// output channel: o_valid/i_stall with o_median, o_item_count, o_refused;
// one result word per input word, in order
// an item that finds the store full skips the heap work; any other item
// runs the sift loops, which walk one heap level per cycle through the
// single write port of each heap RAM, with insert, extract and reinsert
// run one after another; its result word is valid from the cycle in which
// the next word can be taken
// a sample that arrives with 2*HEAP_DEPTH-2 samples held is refused and
// answered with the unchanged median and count
// a new word is taken while the last result still waits; a stalled result
// holds, and the next one waits in the controller until it is taken
// reset empties both heaps by clearing their counts; no clearing pass
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [DATA_W-1:0]               i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [DATA_W-1:0]               o_median,
    output logic [$clog2(2*HEAP_DEPTH)-1:0] o_item_count,
    output logic                            o_refused
);

    t_cmd  cmd;
    t_stat stat;

    rmth_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    rmth_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_sample     (i_sample),
        .o_median     (o_median),
        .o_item_count (o_item_count),
        .o_refused    (o_refused)
    );

endmodule
